// File: src/sbfce_pkg.sv
// Package for the spectral bin floor/compress/envelope block.
// Holds payload structs, register indexes, reset values and shared arithmetic.
// No dependencies.
package sbfce_pkg;

  // Default bin count; bin_index is 6 bits, so at most 64 bins are addressable.
  localparam int NUM_BINS_DEF = 64;
  localparam int BIN_W        = 6;

  // Configuration register indexes.
  localparam logic [7:0] CFG_FLOOR_ALPHA   = 8'd0;
  localparam logic [7:0] CFG_ATTACK_ALPHA  = 8'd1;
  localparam logic [7:0] CFG_RELEASE_ALPHA = 8'd2;
  localparam logic [7:0] CFG_KNEE_CONSTANT = 8'd3;

  // Configuration reset values.
  localparam logic [15:0] FLOOR_ALPHA_RST   = 16'd210;
  localparam logic [15:0] ATTACK_ALPHA_RST  = 16'd18350;
  localparam logic [15:0] RELEASE_ALPHA_RST = 16'd4194;
  localparam logic [19:0] KNEE_CONSTANT_RST = 20'd35289;

  // Item operations.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  // Divider layout: 16 quotient bits, two per stage.
  localparam int DIV_BITS      = 16;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

  typedef struct packed {
    logic               op;
    logic [5:0]         bin_index;
    logic signed [31:0] sample;
    logic [17:0]        weight_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  out_bin;
    logic [15:0] out_level;
  } out_item_t;

  // Partial state of the restoring divider.
  typedef struct packed {
    logic [32:0] rem;
    logic [32:0] den;
    logic [15:0] quo;
  } div_st_t;

  // Move cur toward tgt by (coef * |tgt - cur|) >> 16, truncated.
  function automatic logic [31:0] ema_toward(logic [31:0] cur, logic [31:0] tgt,
                                             logic [15:0] coef);
    logic [31:0] diff;
    logic [47:0] prod;
    logic [31:0] step;
    diff = (tgt >= cur) ? (tgt - cur) : (cur - tgt);
    prod = {32'd0, coef} * {16'd0, diff};
    step = prod[47:16];
    return (tgt >= cur) ? (cur + step) : (cur - step);
  endfunction

  // Two restoring division steps; the remainder stays below the divisor.
  function automatic div_st_t div_steps(div_st_t s);
    div_st_t     t;
    logic [33:0] r2;
    t = s;
    for (int k = 0; k < DIV_PER_STAGE; k++) begin
      r2    = {t.rem, 1'b0};
      t.quo = {t.quo[14:0], 1'b0};
      if (r2 >= {1'b0, t.den}) begin
        r2       = r2 - {1'b0, t.den};
        t.quo[0] = 1'b1;
      end
      t.rem = r2[32:0];
    end
    return t;
  endfunction

endpackage

// File: src/spectral_bin_floor_compress_envelope.sv
// Top level of the spectral bin floor/compress/envelope follower.
// Depends on sbfce_pkg for payload structs, register codes and arithmetic helpers.
//
//   channel | ports                          | direction
//   --------+--------------------------------+-----------
//   input   | in_valid in_ready in_data      | in
//   result  | out_valid out_ready out_data   | out
//   config  | cfg_valid cfg_ready cfg_index  | in
//           | cfg_data                       |
//
// One beat enters per cycle while the output is not stalled. A processed sample
// passes weight read, weight multiply, floor update, subtract and add, eight
// two-bit divider stages, envelope read, then the envelope update into the output register.
// Per-bin floor and envelope updates close in one stage each, with a bypass so
// back-to-back beats on the same bin see the latest value.
// Reset is synchronous; valid bits clear all stores at once, no clearing pass.
// A stall at the output freezes the whole pipeline and the stores.
module spectral_bin_floor_compress_envelope #(
  parameter int NUM_BINS = sbfce_pkg::NUM_BINS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sbfce_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbfce_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import sbfce_pkg::*;

  localparam int DEPTH = (NUM_BINS < 64) ? NUM_BINS : 64;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [15:0] floor_alpha_r, attack_alpha_r, release_alpha_r;
  logic [19:0] knee_r;

  // Per-bin stores and their valid bits.
  logic [17:0] wmem  [DEPTH];
  logic [31:0] flmem [DEPTH];
  logic [15:0] emem  [DEPTH];
  logic [DEPTH-1:0] wvld_r, flvld_r, evld_r;

  // Pipeline registers.
  logic        adv;
  logic        in_take, in_ok;
  logic        a_vld_r, b_vld_r, c_vld_r, e_vld_r, out_vld_r;
  logic [5:0]  a_bin_r, b_bin_r, c_bin_r, e_bin_r, out_bin_r;
  logic [30:0] a_x_r;
  logic [17:0] a_wt_r;
  logic [31:0] b_w_r, b_fl_r, c_w_r, c_fl_r;
  logic [15:0] e_comp_r, e_env_r, out_level_r;
  logic        dv_vld_r [DIV_STAGES+1];
  logic [5:0]  dv_bin_r [DIV_STAGES+1];
  div_st_t     dv_r     [DIV_STAGES+1];
  logic        dv_spc_r [DIV_STAGES+1];
  logic        dv_cap_r [DIV_STAGES+1];

  // Combinational values.
  logic [48:0] a_prod;
  logic [31:0] a_w;
  logic [31:0] fl_new;
  logic [31:0] c_y;
  logic [32:0] c_den;
  logic        c_spc;
  logic [15:0] d_comp;
  logic [15:0] e_alpha;
  logic [31:0] env_wide;
  logic [15:0] env_new;
  logic [AW-1:0] in_idx, a_idx, b_idx, d_idx, e_idx;

  assign adv       = !out_vld_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && adv;
  assign in_ok     = 32'(in_data.bin_index) < DEPTH;

  assign in_idx = in_data.bin_index[AW-1:0];
  assign a_idx  = a_bin_r[AW-1:0];
  assign b_idx  = b_bin_r[AW-1:0];
  assign d_idx  = dv_bin_r[DIV_STAGES][AW-1:0];
  assign e_idx  = e_bin_r[AW-1:0];

  // Weighting: Q16.16 times Q2.16, saturated to 32 bits.
  assign a_prod = {18'd0, a_x_r} * {31'd0, a_wt_r};
  assign a_w    = (a_prod[48:16] > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : a_prod[47:16];

  // Noise floor update for the bin in stage B.
  assign fl_new = ema_toward(b_fl_r, b_w_r, floor_alpha_r);

  // Floor removal and divisor for the compression ratio.
  assign c_y   = (c_w_r > c_fl_r) ? (c_w_r - c_fl_r) : 32'd0;
  assign c_den = {1'b0, c_y} + {13'd0, knee_r};
  assign c_spc = {1'b0, c_y} >= c_den;

  // Quotient, with the zero-divisor and ratio-of-one cases.
  always_comb begin
    if (dv_spc_r[DIV_STAGES]) begin
      d_comp = dv_cap_r[DIV_STAGES] ? 16'hFFFF : 16'd0;
    end else begin
      d_comp = dv_r[DIV_STAGES].quo;
    end
  end

  // Envelope update for the bin in stage E.
  assign e_alpha  = (e_comp_r > e_env_r) ? attack_alpha_r : release_alpha_r;
  assign env_wide = ema_toward({16'd0, e_env_r}, {16'd0, e_comp_r}, e_alpha);
  assign env_new  = env_wide[15:0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_alpha_r   <= FLOOR_ALPHA_RST;
      attack_alpha_r  <= ATTACK_ALPHA_RST;
      release_alpha_r <= RELEASE_ALPHA_RST;
      knee_r          <= KNEE_CONSTANT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FLOOR_ALPHA:   floor_alpha_r   <= cfg_data[15:0];
        CFG_ATTACK_ALPHA:  attack_alpha_r  <= cfg_data[15:0];
        CFG_RELEASE_ALPHA: release_alpha_r <= cfg_data[15:0];
        CFG_KNEE_CONSTANT: knee_r          <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Control state: stage valid bits and store valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      e_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      wvld_r    <= '0;
      flvld_r   <= '0;
      evld_r    <= '0;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        dv_vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      a_vld_r     <= in_take && in_ok && (in_data.op == OP_PROCESS);
      b_vld_r     <= a_vld_r;
      c_vld_r     <= b_vld_r;
      dv_vld_r[0] <= c_vld_r;
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_vld_r[k+1] <= dv_vld_r[k];
      end
      e_vld_r   <= dv_vld_r[DIV_STAGES];
      out_vld_r <= e_vld_r;
      if (in_take && in_ok && (in_data.op == OP_LOAD)) begin
        wvld_r[in_idx] <= 1'b1;
      end
      if (b_vld_r) begin
        flvld_r[b_idx] <= 1'b1;
      end
      if (e_vld_r) begin
        evld_r[e_idx] <= 1'b1;
      end
    end
  end

  // Stores: weight written by load beats, floor and envelope by their stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_take && in_ok && (in_data.op == OP_LOAD)) begin
        wmem[in_idx] <= in_data.weight_value;
      end
      if (b_vld_r) begin
        flmem[b_idx] <= fl_new;
      end
      if (e_vld_r) begin
        emem[e_idx] <= env_new;
      end
    end
  end

  // Payload path.
  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage A: clamp sample, read weight.
      a_bin_r <= in_data.bin_index;
      a_x_r   <= in_data.sample[31] ? 31'd0 : in_data.sample[30:0];
      a_wt_r  <= wvld_r[in_idx] ? wmem[in_idx] : 18'd0;

      // Stage B: weighted value, floor read with bypass from stage B.
      b_bin_r <= a_bin_r;
      b_w_r   <= a_w;
      if (b_vld_r && (b_bin_r == a_bin_r)) begin
        b_fl_r <= fl_new;
      end else begin
        b_fl_r <= flvld_r[a_idx] ? flmem[a_idx] : 32'd0;
      end

      // Stage C: updated floor.
      c_bin_r <= b_bin_r;
      c_w_r   <= b_w_r;
      c_fl_r  <= fl_new;

      // Divider entry.
      dv_bin_r[0]     <= c_bin_r;
      dv_spc_r[0]     <= c_spc;
      dv_cap_r[0]     <= c_den != 33'd0;
      dv_r[0].rem     <= c_spc ? 33'd0 : {1'b0, c_y};
      dv_r[0].den     <= c_den;
      dv_r[0].quo     <= 16'd0;

      // Divider stages.
      for (int k = 0; k < DIV_STAGES; k++) begin
        dv_bin_r[k+1] <= dv_bin_r[k];
        dv_spc_r[k+1] <= dv_spc_r[k];
        dv_cap_r[k+1] <= dv_cap_r[k];
        dv_r[k+1]     <= div_steps(dv_r[k]);
      end

      // Stage E: envelope read with bypass from stage E.
      e_bin_r  <= dv_bin_r[DIV_STAGES];
      e_comp_r <= d_comp;
      if (e_vld_r && (e_bin_r == dv_bin_r[DIV_STAGES])) begin
        e_env_r <= env_new;
      end else begin
        e_env_r <= evld_r[d_idx] ? emem[d_idx] : 16'd0;
      end

      // Output register.
      out_bin_r   <= e_bin_r;
      out_level_r <= env_new;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_data.out_bin   = out_bin_r;
  assign out_data.out_level = out_level_r;

endmodule
